>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the Merkle tree builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`endif

>>> rtl/core/mtsb_pkg.sv
// Shared types, constants and helper functions of the Merkle tree builder.
`timescale 1ns / 1ps
`default_nettype none
package mtsb_pkg;

  localparam logic [1:0] K_APPEND = 2'd0;
  localparam logic [1:0] K_FINISH = 2'd1;
  localparam logic [1:0] K_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_STORE = 2'd2;

  localparam logic [7:0] TAG_L = 8'h4C;
  localparam logic [7:0] TAG_P = 8'h50;
  localparam logic [7:0] TAG_R = 8'h52;
  localparam logic [31:0] TAG_HEAD = 32'h4F4E452D;

  localparam int CNT_W = 14;

  localparam logic [255:0] SHA_IV = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       fin_valid;
  } hs_ctl_t;

  typedef struct packed {
    logic byte_ready;
    logic fin_ready;
    logic done;
  } hs_stat_t;

  function automatic logic [7:0] le_byte(logic [63:0] v, logic [2:0] k);
    return v[8*k +: 8];
  endfunction

  function automatic logic [7:0] tag_byte(logic [7:0] c, logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0: b = TAG_HEAD[31:24];
      3'd1: b = TAG_HEAD[23:16];
      3'd2: b = TAG_HEAD[15:8];
      3'd3: b = TAG_HEAD[7:0];
      3'd4: b = c;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/mtsb_sha_core.sv
// SHA-256 compression unit that runs one round per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mtsb_sha_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [511:0] blk,
  input  logic [255:0] h_in,
  output logic         done,
  output logic [255:0] h_out
);

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [5:0]  rnd;
  logic        busy;
  logic [31:0] t1, t2, w_new, s0, s1;

  always_comb begin
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + mtsb_pkg::SHA_K[rnd] + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    for (int i = 0; i < 8; i++) begin
      h_out[255-32*i -: 32] = h_in[255-32*i -: 32] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= busy && (rnd == 6'd63);
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= blk[511-32*i -: 32];
      end
      for (int i = 0; i < 8; i++) begin
        v[i] <= h_in[255-32*i -: 32];
      end
    end else if (busy) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mtsb_hasher.sv
// Byte-stream SHA-256 front end with block assembly and padding.
`timescale 1ns / 1ps
`default_nettype none
module mtsb_hasher (
  input  logic               clk,
  input  logic               rst,
  input  mtsb_pkg::hs_ctl_t  ctl,
  output mtsb_pkg::hs_stat_t stat,
  output logic [255:0]       digest
);

  localparam logic [1:0] H_IDLE  = 2'd0;
  localparam logic [1:0] H_START = 2'd1;
  localparam logic [1:0] H_WAIT  = 2'd2;
  localparam logic [1:0] H_DONE  = 2'd3;

  localparam logic [1:0] P_MARK = 2'd0;
  localparam logic [1:0] P_ZERO = 2'd1;
  localparam logic [1:0] P_LEN  = 2'd2;

  logic [1:0]                 st;
  logic [1:0]                 pstage;
  logic                       pad_on;
  logic                       last_blk;
  logic [5:0]                 fill;
  logic [mtsb_pkg::CNT_W-1:0] count;
  logic [255:0]               h;
  logic [511:0]               blk;
  logic                       eff_len;
  logic                       take;
  logic [7:0]                 bval;
  logic [63:0]                bits64;
  logic                       core_done;
  logic [255:0]               core_h;

  assign bits64  = 64'({count, 3'b000});
  assign eff_len = (pstage == P_LEN) || ((pstage == P_ZERO) && (fill == 6'd56));
  assign take    = (st == H_IDLE) && (pad_on || ctl.byte_valid);

  always_comb begin
    if (!pad_on) begin
      bval = ctl.byte_data;
    end else if (pstage == P_MARK) begin
      bval = 8'h80;
    end else if (eff_len) begin
      bval = bits64[8*(7 - fill[2:0]) +: 8];
    end else begin
      bval = 8'h00;
    end
  end

  assign stat.byte_ready = (st == H_IDLE) && !pad_on;
  assign stat.fin_ready  = (st == H_IDLE) && !pad_on;
  assign stat.done       = (st == H_DONE);
  assign digest          = h;

  mtsb_sha_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (st == H_START),
    .blk   (blk),
    .h_in  (h),
    .done  (core_done),
    .h_out (core_h)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= H_IDLE;
      pstage   <= P_MARK;
      pad_on   <= 1'b0;
      last_blk <= 1'b0;
      fill     <= '0;
      count    <= '0;
      h        <= mtsb_pkg::SHA_IV;
    end else begin
      unique case (st)
        H_IDLE: begin
          if (ctl.fin_valid && !pad_on) begin
            pad_on <= 1'b1;
            pstage <= P_MARK;
          end else if (take) begin
            fill <= fill + 6'd1;
            if (!pad_on) begin
              count <= count + 1'b1;
            end else if (pstage == P_MARK) begin
              pstage <= P_ZERO;
            end else if (eff_len) begin
              pstage <= P_LEN;
              if (fill == 6'd63) begin
                last_blk <= 1'b1;
              end
            end
            if (fill == 6'd63) begin
              st <= H_START;
            end
          end
        end
        H_START: st <= H_WAIT;
        H_WAIT: begin
          if (core_done) begin
            h  <= core_h;
            st <= last_blk ? H_DONE : H_IDLE;
          end
        end
        H_DONE: begin
          h        <= mtsb_pkg::SHA_IV;
          count    <= '0;
          pad_on   <= 1'b0;
          pstage   <= P_MARK;
          last_blk <= 1'b0;
          st       <= H_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && !(ctl.fin_valid && !pad_on)) begin
      blk[8*(63 - fill) +: 8] <= bval;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/merkle_tree_sha256_builder.sv
// Top level of the SHA-256 Merkle tree builder with its message and node memories.
//
//   channel  signals                                    direction
//   cfg      cfg_valid cfg_ready cfg_data               write, leaf size
//   in       in_valid in_ready kind data_byte node_index request in
//   out      out_valid out_ready digest_word ...        result out
//
// An append or ignored request is taken while idle. A read of a built node fetches it
// from node memory and gives four result words. A finish without overflow counts
// leaves at one leaf per cycle, then feeds the hash unit one byte per cycle while it is
// ready; each message byte waits for its memory read, each block for its rounds.
// Synchronous reset; no clearing pass. Configuration is taken only while idle.
// The output holds while stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module merkle_tree_sha256_builder #(
  parameter int MAX_MESSAGE_BYTES = 4096,
  parameter int MAX_NODES         = 511
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [8:0]  node_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [1:0]  word_number,
  output logic        is_root,
  output logic [8:0]  node_total,
  output logic [1:0]  status,
  output logic        last
);

  localparam int LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int MA_W  = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
  localparam int NC_W  = $clog2(MAX_NODES + 1);
  localparam int NA_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int TW    = LEN_W + 2;
  localparam int SW    = ((LEN_W > 13) ? LEN_W : 13) + 1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CNT   = 5'd1;
  localparam logic [4:0] S_TOT   = 5'd2;
  localparam logic [4:0] S_LSET  = 5'd3;
  localparam logic [4:0] S_LTAG  = 5'd4;
  localparam logic [4:0] S_LIDX  = 5'd5;
  localparam logic [4:0] S_LLEN  = 5'd6;
  localparam logic [4:0] S_LMRD  = 5'd7;
  localparam logic [4:0] S_LMSG  = 5'd8;
  localparam logic [4:0] S_HFIN  = 5'd9;
  localparam logic [4:0] S_HWAIT = 5'd10;
  localparam logic [4:0] S_PTAG  = 5'd11;
  localparam logic [4:0] S_PLVL  = 5'd12;
  localparam logic [4:0] S_NRD   = 5'd13;
  localparam logic [4:0] S_NODE  = 5'd14;
  localparam logic [4:0] S_RTAG  = 5'd15;
  localparam logic [4:0] S_RLEN  = 5'd16;
  localparam logic [4:0] S_RLB   = 5'd17;
  localparam logic [4:0] S_RDCAP = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  localparam logic [2:0] PH_LEAF  = 3'd0;
  localparam logic [2:0] PH_LEFT  = 3'd1;
  localparam logic [2:0] PH_RIGHT = 3'd2;
  localparam logic [2:0] PH_TOP   = 3'd3;
  localparam logic [2:0] PH_READ  = 3'd4;

  logic [4:0]       state;
  logic [2:0]       ph;
  logic [5:0]       cnt;
  logic [12:0]      leaf_size;
  logic [12:0]      lb;
  logic [LEN_W-1:0] msg_len;
  logic             ovf;
  logic [NC_W-1:0]  built;
  logic [LEN_W-1:0] flen;
  logic [LEN_W-1:0] rem;
  logic [TW-1:0]    leaves;
  logic [TW-1:0]    width;
  logic [TW-1:0]    total;
  logic [TW-1:0]    leaf_i;
  logic [SW-1:0]    start;
  logic [MA_W-1:0]  mptr;
  logic [LEN_W-1:0] mrem;
  logic [TW-1:0]    prevb;
  logic [TW-1:0]    wr_ptr;
  logic [TW-1:0]    lpos;
  logic [7:0]       level;
  logic [NA_W-1:0]  rd_idx;
  logic [255:0]     dig;
  logic             o_root;
  logic [1:0]       o_status;
  logic [8:0]       o_total;
  logic             multi;
  logic [1:0]       wn;

  logic [7:0]       msg_mem [MAX_MESSAGE_BYTES];
  logic [7:0]       msg_q;
  logic [255:0]     node_mem [MAX_NODES];
  logic [255:0]     node_q;

  mtsb_pkg::hs_ctl_t  hs_ctl;
  mtsb_pkg::hs_stat_t hs_stat;
  logic [255:0]       hs_digest;

  logic [5:0]  seg_len;
  logic        push;
  logic        seg_end;
  logic        msg_we;
  logic        node_we;
  logic [31:0] nrd_wide;
  logic [31:0] nwr_wide;
  logic [31:0] tot32;
  logic [31:0] blt32;
  logic [31:0] ni32;
  logic [31:0] lrem32;
  logic [TW-1:0] nw;

  assign lb       = (leaf_size == 13'd0) ? 13'd1 : leaf_size;
  assign tot32    = 32'(total);
  assign blt32    = 32'(built);
  assign ni32     = 32'(node_index);
  assign lrem32   = 32'(flen) - 32'(start);
  assign nw       = TW'((width + TW'(1)) >> 1);
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);
  assign msg_we    = in_valid && in_ready && (kind == mtsb_pkg::K_APPEND)
                     && (32'(msg_len) < 32'(MAX_MESSAGE_BYTES));
  assign node_we   = (state == S_HWAIT) && hs_stat.done
                     && ((ph == PH_LEAF) || (ph == PH_RIGHT));
  assign nwr_wide  = (ph == PH_LEAF) ? 32'(leaf_i) : 32'(wr_ptr);

  always_comb begin
    unique case (ph)
      PH_LEFT:  nrd_wide = 32'(prevb) + 32'(lpos);
      PH_RIGHT: nrd_wide = (32'(lpos) + 32'd1 < 32'(width)) ? 32'(prevb) + 32'(lpos) + 32'd1
                                                            : 32'(prevb) + 32'(lpos);
      PH_TOP:   nrd_wide = tot32 - 32'd1;
      default:  nrd_wide = 32'(rd_idx);
    endcase
  end

  always_comb begin
    hs_ctl.byte_valid = 1'b1;
    hs_ctl.byte_data  = 8'h00;
    hs_ctl.fin_valid  = (state == S_HFIN);
    seg_len           = 6'd1;
    unique case (state)
      S_LTAG: begin
        hs_ctl.byte_data = mtsb_pkg::tag_byte(mtsb_pkg::TAG_L, cnt[2:0]);
        seg_len          = 6'd6;
      end
      S_PTAG: begin
        hs_ctl.byte_data = mtsb_pkg::tag_byte(mtsb_pkg::TAG_P, cnt[2:0]);
        seg_len          = 6'd6;
      end
      S_RTAG: begin
        hs_ctl.byte_data = mtsb_pkg::tag_byte(mtsb_pkg::TAG_R, cnt[2:0]);
        seg_len          = 6'd6;
      end
      S_LIDX: begin
        hs_ctl.byte_data = mtsb_pkg::le_byte(64'(leaf_i), cnt[2:0]);
        seg_len          = 6'd8;
      end
      S_LLEN, S_RLEN: begin
        hs_ctl.byte_data = mtsb_pkg::le_byte(64'(flen), cnt[2:0]);
        seg_len          = 6'd8;
      end
      S_PLVL: begin
        hs_ctl.byte_data = mtsb_pkg::le_byte(64'(level), cnt[2:0]);
        seg_len          = 6'd4;
      end
      S_RLB: begin
        hs_ctl.byte_data = mtsb_pkg::le_byte(64'(lb), cnt[2:0]);
        seg_len          = 6'd4;
      end
      S_NODE: begin
        hs_ctl.byte_data = node_q[8*(31 - cnt[4:0]) +: 8];
        seg_len          = 6'd32;
      end
      S_LMSG: hs_ctl.byte_data = msg_q;
      default: hs_ctl.byte_valid = 1'b0;
    endcase
  end

  assign push    = hs_ctl.byte_valid && hs_stat.byte_ready;
  assign seg_end = (cnt == seg_len - 6'd1);

  mtsb_hasher u_hasher (
    .clk    (clk),
    .rst    (rst),
    .ctl    (hs_ctl),
    .stat   (hs_stat),
    .digest (hs_digest)
  );

  always_ff @(posedge clk) begin
    if (msg_we) begin
      msg_mem[msg_len[MA_W-1:0]] <= data_byte;
    end
    if (state == S_LMRD) begin
      msg_q <= msg_mem[mptr];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[nwr_wide[NA_W-1:0]] <= hs_digest;
    end
    if (state == S_NRD) begin
      node_q <= node_mem[nrd_wide[NA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= PH_LEAF;
      cnt       <= '0;
      leaf_size <= 13'd64;
      msg_len   <= '0;
      ovf       <= 1'b0;
      built     <= '0;
      wn        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        leaf_size <= cfg_data;
      end
      if (push) begin
        cnt <= seg_end ? 6'd0 : cnt + 6'd1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (kind)
              mtsb_pkg::K_APPEND: begin
                if (32'(msg_len) < 32'(MAX_MESSAGE_BYTES)) begin
                  msg_len <= msg_len + 1'b1;
                end else begin
                  ovf <= 1'b1;
                end
              end
              mtsb_pkg::K_FINISH: begin
                msg_len <= '0;
                ovf     <= 1'b0;
                flen    <= msg_len;
                rem     <= msg_len;
                leaves  <= '0;
                if (ovf) begin
                  dig      <= '0;
                  o_root   <= 1'b0;
                  o_status <= mtsb_pkg::ST_OVF;
                  o_total  <= '0;
                  multi    <= 1'b0;
                  wn       <= '0;
                  state    <= S_OUT;
                end else begin
                  state <= S_CNT;
                end
              end
              mtsb_pkg::K_READ: begin
                if ((ni32 < blt32) && (ni32 < 32'(MAX_NODES))) begin
                  rd_idx <= ni32[NA_W-1:0];
                  ph     <= PH_READ;
                  state  <= S_NRD;
                end else begin
                  dig      <= '0;
                  o_root   <= 1'b0;
                  o_status <= mtsb_pkg::ST_STORE;
                  o_total  <= blt32[8:0];
                  multi    <= 1'b0;
                  wn       <= '0;
                  state    <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_CNT: begin
          if (rem == '0) begin
            leaves <= (leaves == '0) ? TW'(1) : leaves;
            width  <= (leaves == '0) ? TW'(1) : leaves;
            total  <= '0;
            state  <= S_TOT;
          end else begin
            leaves <= leaves + TW'(1);
            rem    <= (32'(rem) > 32'(lb)) ? rem - LEN_W'(lb) : '0;
          end
        end
        S_TOT: begin
          total <= total + width;
          if (width == TW'(1)) begin
            if (tot32 + 32'(width) > 32'(MAX_NODES)) begin
              dig      <= '0;
              o_root   <= 1'b0;
              o_status <= mtsb_pkg::ST_STORE;
              o_total  <= '0;
              multi    <= 1'b0;
              wn       <= '0;
              state    <= S_OUT;
            end else begin
              leaf_i <= '0;
              start  <= '0;
              state  <= S_LSET;
            end
          end else begin
            width <= nw;
          end
        end
        S_LSET: begin
          if (32'(start) < 32'(flen)) begin
            mptr <= start[MA_W-1:0];
            mrem <= (lrem32 > 32'(lb)) ? LEN_W'(lb) : lrem32[LEN_W-1:0];
          end else begin
            mrem <= '0;
          end
          ph    <= PH_LEAF;
          state <= S_LTAG;
        end
        S_LTAG: if (push && seg_end) state <= S_LIDX;
        S_LIDX: if (push && seg_end) state <= S_LLEN;
        S_LLEN: if (push && seg_end) state <= (mrem == '0) ? S_HFIN : S_LMRD;
        S_LMRD: state <= S_LMSG;
        S_LMSG: begin
          if (push) begin
            mptr  <= mptr + 1'b1;
            mrem  <= mrem - 1'b1;
            state <= (mrem == LEN_W'(1)) ? S_HFIN : S_LMRD;
          end
        end
        S_HFIN: if (hs_stat.fin_ready) state <= S_HWAIT;
        S_HWAIT: begin
          if (hs_stat.done) begin
            unique case (ph)
              PH_LEAF: begin
                leaf_i <= leaf_i + TW'(1);
                start  <= start + SW'(lb);
                if (leaf_i + TW'(1) == leaves) begin
                  if (leaves == TW'(1)) begin
                    ph    <= PH_TOP;
                    state <= S_RTAG;
                  end else begin
                    prevb  <= '0;
                    wr_ptr <= leaves;
                    width  <= leaves;
                    level  <= 8'd1;
                    lpos   <= '0;
                    state  <= S_PTAG;
                  end
                end else begin
                  state <= S_LSET;
                end
              end
              PH_RIGHT: begin
                wr_ptr <= wr_ptr + TW'(1);
                if (32'(lpos) + 32'd2 >= 32'(width)) begin
                  prevb <= prevb + width;
                  width <= nw;
                  level <= level + 8'd1;
                  lpos  <= '0;
                  if (nw == TW'(1)) begin
                    ph    <= PH_TOP;
                    state <= S_RTAG;
                  end else begin
                    state <= S_PTAG;
                  end
                end else begin
                  lpos  <= lpos + TW'(2);
                  state <= S_PTAG;
                end
              end
              PH_TOP: begin
                dig      <= hs_digest;
                o_root   <= 1'b1;
                o_status <= mtsb_pkg::ST_OK;
                o_total  <= tot32[8:0];
                multi    <= 1'b1;
                wn       <= '0;
                built    <= tot32[NC_W-1:0];
                state    <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PTAG: if (push && seg_end) state <= S_PLVL;
        S_PLVL: begin
          if (push && seg_end) begin
            ph    <= PH_LEFT;
            state <= S_NRD;
          end
        end
        S_NRD: state <= (ph == PH_READ) ? S_RDCAP : S_NODE;
        S_NODE: begin
          if (push && seg_end) begin
            if (ph == PH_LEFT) begin
              ph    <= PH_RIGHT;
              state <= S_NRD;
            end else begin
              state <= S_HFIN;
            end
          end
        end
        S_RTAG: if (push && seg_end) state <= S_RLEN;
        S_RLEN: if (push && seg_end) state <= S_RLB;
        S_RLB:  if (push && seg_end) state <= S_NRD;
        S_RDCAP: begin
          dig      <= node_q;
          o_root   <= 1'b0;
          o_status <= mtsb_pkg::ST_OK;
          o_total  <= blt32[8:0];
          multi    <= 1'b1;
          wn       <= '0;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            wn <= wn + 2'd1;
            if (!multi || (wn == 2'd3)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = (state == S_OUT);
  assign digest_word = dig[64*(3 - wn) +: 64];
  assign word_number = wn;
  assign is_root     = o_root;
  assign node_total  = o_total;
  assign status      = o_status;
  assign last        = !multi || (wn == 2'd3);

  `ASSERT_IMPLIES(a_out_blocks_in, clk, rst, out_valid, !in_ready)
  `ASSERT_IMPLIES(a_done_in_wait, clk, rst, hs_stat.done, state == S_HWAIT)
  `ASSERT_IMPLIES(a_error_single, clk, rst, out_valid && (status != mtsb_pkg::ST_OK), last && (word_number == 2'd0))
  `ASSERT_NEXT(a_back_to_idle, clk, rst, out_valid && out_ready && last, in_ready)

endmodule
`default_nettype wire

>>> tb/merkle_tree_sha256_builder_tb.sv
// Self-checking testbench for the SHA-256 Merkle tree builder, with its own hashing predictor.
`timescale 1ns / 1ps
module merkle_tree_sha256_builder_tb;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic [8:0] idx;
  } request_t;

  typedef struct {
    logic [63:0] word;
    logic [1:0]  num;
    logic        root;
    logic [8:0]  total;
    logic [1:0]  st;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data = 13'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = mtsb_pkg::K_APPEND;
  logic [7:0]  data_byte = 8'd0;
  logic [8:0]  node_index = 9'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest_word;
  logic [1:0]  word_number;
  logic        is_root;
  logic [8:0]  node_total;
  logic [1:0]  status;
  logic        last;

  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;

  request_t     pending_reqs[$];
  digest_word_t expected_words[$];

  logic [7:0]   msg_bytes[$];
  logic         msg_overflow = 1'b0;
  logic [255:0] node_mem[511];
  int           built_nodes = 0;
  int           leaf_cfg = 64;

  int errors = 0;
  int n_items = 0;
  int n_words = 0;
  int n_finish = 0;
  int n_read = 0;
  int n_cfg = 0;

  merkle_tree_sha256_builder uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .data_byte(data_byte), .node_index(node_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_number(word_number), .is_root(is_root),
    .node_total(node_total), .status(status), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results still expected", expected_words.size());
    $display("merkle_tree_sha256_builder_tb: FAIL");
    $finish;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha256_of(input logic [7:0] msg[$]);
    logic [31:0] h[8];
    logic [31:0] v[8];
    logic [31:0] w[64];
    logic [31:0] s0, s1, t1, t2;
    logic [63:0] bitlen;
    logic [255:0] d;
    bitlen = 64'(msg.size()) * 8;
    msg.push_back(8'h80);
    while (msg.size() % 64 != 56) msg.push_back(8'h00);
    for (int i = 0; i < 8; i++) msg.push_back(bitlen[63 - 8 * i -: 8]);
    for (int i = 0; i < 8; i++) h[i] = mtsb_pkg::SHA_IV[255 - 32 * i -: 32];
    for (int b = 0; b < msg.size() / 64; b++) begin
      for (int t = 0; t < 16; t++) begin
        w[t] = {msg[64 * b + 4 * t], msg[64 * b + 4 * t + 1],
                msg[64 * b + 4 * t + 2], msg[64 * b + 4 * t + 3]};
      end
      for (int t = 16; t < 64; t++) begin
        s0 = ror32(w[t - 15], 7) ^ ror32(w[t - 15], 18) ^ (w[t - 15] >> 3);
        s1 = ror32(w[t - 2], 17) ^ ror32(w[t - 2], 19) ^ (w[t - 2] >> 10);
        w[t] = w[t - 16] + s0 + w[t - 7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = h[i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + mtsb_pkg::SHA_K[t] + w[t];
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
    end
    for (int i = 0; i < 8; i++) d[255 - 32 * i -: 32] = h[i];
    return d;
  endfunction

  function automatic void put_tag(ref logic [7:0] q[$], input logic [7:0] letter);
    for (int i = 0; i < 4; i++) q.push_back(mtsb_pkg::TAG_HEAD[31 - 8 * i -: 8]);
    q.push_back(letter);
    q.push_back(8'h00);
  endfunction

  function automatic void put_le(ref logic [7:0] q[$], input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) q.push_back(v[8 * i +: 8]);
  endfunction

  function automatic void put_node(ref logic [7:0] q[$], input logic [255:0] d);
    for (int i = 0; i < 32; i++) q.push_back(d[255 - 8 * i -: 8]);
  endfunction

  function automatic void expect_digest(logic [255:0] d, logic root, int total);
    digest_word_t r;
    for (int k = 0; k < 4; k++) begin
      r.word = d[255 - 64 * k -: 64];
      r.num = 2'(k);
      r.root = root;
      r.total = 9'(total);
      r.st = mtsb_pkg::ST_OK;
      r.last = (k == 3);
      expected_words.push_back(r);
    end
  endfunction

  function automatic void expect_error(int total, logic [1:0] st);
    digest_word_t r;
    r.word = 64'd0;
    r.num = 2'd0;
    r.root = 1'b0;
    r.total = 9'(total);
    r.st = st;
    r.last = 1'b1;
    expected_words.push_back(r);
  endfunction

  function automatic void build_tree();
    logic [7:0] q[$];
    int len, lb, leaves, total, width, prev, wr, level, nw, l, r, start, n;
    logic ovf;
    len = msg_bytes.size();
    lb = (leaf_cfg == 0) ? 1 : leaf_cfg;
    leaves = (len != 0) ? (len + lb - 1) / lb : 1;
    ovf = msg_overflow;
    msg_overflow = 1'b0;
    total = 0;
    width = leaves;
    forever begin
      total += width;
      if (width == 1) break;
      width = (width + 1) / 2;
    end
    if (ovf) begin
      expect_error(0, mtsb_pkg::ST_OVF);
    end else if (total > 511) begin
      expect_error(0, mtsb_pkg::ST_STORE);
    end else begin
      for (int i = 0; i < leaves; i++) begin
        start = i * lb;
        n = (start < len) ? ((len - start > lb) ? lb : len - start) : 0;
        q.delete();
        put_tag(q, mtsb_pkg::TAG_L);
        put_le(q, i, 8);
        put_le(q, len, 8);
        for (int j = 0; j < n; j++) q.push_back(msg_bytes[start + j]);
        node_mem[i] = sha256_of(q);
      end
      prev = 0;
      wr = leaves;
      width = leaves;
      level = 1;
      while (width > 1) begin
        nw = (width + 1) / 2;
        for (int j = 0; j < nw; j++) begin
          l = prev + 2 * j;
          r = (2 * j + 1 < width) ? l + 1 : l;
          q.delete();
          put_tag(q, mtsb_pkg::TAG_P);
          put_le(q, level, 4);
          put_node(q, node_mem[l]);
          put_node(q, node_mem[r]);
          node_mem[wr + j] = sha256_of(q);
        end
        prev = wr;
        wr += nw;
        width = nw;
        level++;
      end
      built_nodes = total;
      q.delete();
      put_tag(q, mtsb_pkg::TAG_R);
      put_le(q, len, 8);
      put_le(q, lb, 4);
      put_node(q, node_mem[total - 1]);
      expect_digest(sha256_of(q), 1'b1, total);
    end
    msg_bytes.delete();
  endfunction

  function automatic void predict(logic [1:0] k, logic [7:0] b, logic [8:0] idx);
    case (k)
      mtsb_pkg::K_APPEND: begin
        if (msg_bytes.size() < 4096) msg_bytes.push_back(b);
        else msg_overflow = 1'b1;
      end
      mtsb_pkg::K_FINISH: begin
        n_finish++;
        build_tree();
      end
      mtsb_pkg::K_READ: begin
        n_read++;
        if (idx < built_nodes && idx < 511) expect_digest(node_mem[idx], 1'b0, built_nodes);
        else expect_error(built_nodes, mtsb_pkg::ST_STORE);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    digest_word_t e;
    if (rst) begin
      in_fire <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        leaf_cfg = cfg_data;
        n_cfg++;
      end
      if (in_valid && in_ready) begin
        n_items++;
        predict(kind, data_byte, node_index);
      end
      if (out_valid && out_ready) begin
        n_words++;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", digest_word));
        end else begin
          e = expected_words.pop_front();
          if (digest_word !== e.word)
            report_mismatch($sformatf("digest_word %h, expected %h", digest_word, e.word));
          if (word_number !== e.num)
            report_mismatch($sformatf("word_number %0d, expected %0d", word_number, e.num));
          if (is_root !== e.root)
            report_mismatch($sformatf("is_root %b, expected %b", is_root, e.root));
          if (node_total !== e.total)
            report_mismatch($sformatf("node_total %0d, expected %0d", node_total, e.total));
          if (status !== e.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
          if (last !== e.last)
            report_mismatch($sformatf("last %b, expected %b", last, e.last));
        end
      end
    end
  end

  int in_gap = 0;

  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() == 0) begin
      in_valid <= 1'b0;
    end else begin
      r = pending_reqs.pop_front();
      kind <= r.kind;
      data_byte <= r.data;
      node_index <= r.idx;
      in_valid <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 13);
    end
  end

  int out_stall = 0;
  int out_hold = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && out_hold == 0) begin
      hold_req = 1'b0;
      out_hold = 400;
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) out_stall = $urandom_range(1, 13);
    end
  end

  task automatic add_req(logic [1:0] k, logic [7:0] b, logic [8:0] idx);
    request_t r;
    r.kind = k;
    r.data = b;
    r.idx = idx;
    pending_reqs.push_back(r);
  endtask

  task automatic add_bytes(int n);
    for (int i = 0; i < n; i++) add_req(mtsb_pkg::K_APPEND, 8'($urandom), 9'($urandom));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_leaf_size(int v);
    wait_drained();
    cfg_data <= 13'(v);
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_req(mtsb_pkg::K_READ, 8'd0, 9'd0);
    add_req(mtsb_pkg::K_FINISH, 8'd0, 9'd0);
    add_req(mtsb_pkg::K_READ, 8'd0, 9'd0);
    add_req(mtsb_pkg::K_READ, 8'd0, 9'd1);
    add_req(mtsb_pkg::K_READ, 8'd0, 9'd511);
    add_req(2'd3, 8'hFF, 9'h1FF);
    add_req(mtsb_pkg::K_APPEND, 8'h00, 9'd0);
    add_req(mtsb_pkg::K_APPEND, 8'hFF, 9'd0);
    add_req(mtsb_pkg::K_FINISH, 8'd0, 9'd0);
    write_leaf_size(1);
    add_bytes(3);
    add_req(mtsb_pkg::K_FINISH, 8'd0, 9'd0);
    for (int i = 0; i < 7; i++) add_req(mtsb_pkg::K_READ, 8'd0, 9'(i));
    write_leaf_size(4096);
    add_bytes(60);
    add_req(mtsb_pkg::K_FINISH, 8'd0, 9'd0);
    add_req(mtsb_pkg::K_READ, 8'd0, 9'd0);

    for (int p = 0; p < 5; p++) begin
      write_leaf_size((p == 1) ? $urandom_range(17, 4096) : $urandom_range(1, 8));
      if (p == 4) quiet = 1'b1;
      for (int m = 0; m < 4; m++) begin
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
        add_bytes(n);
        if ($urandom_range(0, 7) == 0) add_req(2'd3, 8'($urandom), 9'($urandom));
        add_req(mtsb_pkg::K_FINISH, 8'd0, 9'd0);
        for (int r = $urandom_range(0, 3); r > 0; r--) begin
          if ($urandom_range(0, 3) == 0) add_req(mtsb_pkg::K_READ, 8'($urandom), 9'($urandom));
          else add_req(mtsb_pkg::K_READ, 8'($urandom), 9'($urandom_range(0, 15)));
        end
      end
      if (p == 2) begin
        hold_req = 1'b1;
        for (int r = 0; r < 20; r++) add_req(mtsb_pkg::K_READ, 8'd0, 9'($urandom_range(0, 3)));
      end
    end
    wait_drained();

    $display("Covered %0d requests (%0d finishes, %0d reads) and %0d leaf size writes;",
             n_items, n_finish, n_read, n_cfg);
    $display("checked %0d result words with %0d mismatches.", n_words, errors);
    if (errors == 0) begin
      $display("merkle_tree_sha256_builder_tb: PASS");
    end else begin
      $display("merkle_tree_sha256_builder_tb: FAIL");
    end
    $finish;
  end

endmodule
